// ===== design/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the channel transform design
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// consequence holds in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// consequence holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== design/ect_pkg.sv =====
// -----------------------------------------------------------------------------
// ect_pkg
// Types, constants and the trig microcode of the channel transform block
// -----------------------------------------------------------------------------
`default_nettype none

package ect_pkg;

  // defaults for the top level parameters
  localparam int MAX_CHANNELS_DEF = 6;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int NUM_VALUES       = 6;

  // configuration port
  localparam int CFG_W      = 18;
  localparam int CFG_ADDR_W = 1;
  localparam int COUNT_W    = 3;
  localparam int KINDS_W    = 18;
  localparam int KIND_W     = 3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd6;
  localparam logic [KINDS_W-1:0] KINDS_RESET = 18'd146056;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COUNT = 1'b0,
    REG_KINDS = 1'b1
  } cfg_reg_t;

  // channel codes
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_MOVE_X = 3'd0;
  localparam kind_t KIND_MOVE_Y = 3'd1;
  localparam kind_t KIND_MOVE_Z = 3'd2;
  localparam kind_t KIND_ROT_X  = 3'd3;
  localparam kind_t KIND_ROT_Y  = 3'd4;
  localparam kind_t KIND_ROT_Z  = 3'd5;

  // fixed point
  localparam int ROT_W = 32;
  localparam logic signed [ROT_W-1:0] Q30_ONE = 32'sd1073741824;
  localparam int ANG_W = 25;
  localparam logic [ANG_W-1:0] FULL_TURN    = 25'd23592960;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 25'd5898240;
  localparam logic [ANG_W-1:0] HALF_TURN    = 25'd11796480;
  localparam logic [ANG_W-1:0] THREE_QUART  = 25'd17694720;
  localparam logic [ANG_W-1:0] EIGHTH_TURN  = 25'd2949120;
  localparam int G_W = 22;

  // shared multiplier operands
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;
  localparam longint unsigned DEG2RAD = 64'd1228166276394;
  localparam int DEG_LO_W = 20;
  localparam logic [OP_W-1:0] DEG_HI = OP_W'(DEG2RAD >> DEG_LO_W);
  localparam logic [OP_W-1:0] DEG_LO = OP_W'(DEG2RAD & ((64'd1 << DEG_LO_W) - 64'd1));

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAN,
    S_MOD,
    S_QUAD,
    S_TRIG,
    S_ROT,
    S_MOVE,
    S_DONE
  } state_t;

  // microcode fields
  typedef enum logic [1:0] {A_G, A_X, A_X2, A_WB} a_sel_t;
  typedef enum logic [1:0] {B_DH, B_DL, B_WB, B_RCP} b_sel_t;
  typedef enum logic [1:0] {BASE_ACC, BASE_ZERO, BASE_R29, BASE_R31} base_t;
  typedef enum logic [1:0] {SH0, SH16, SH20} shift_t;
  typedef enum logic [1:0] {WB_NONE, WB_X, WB_MQ, WB_DIV} wb_t;
  typedef enum logic [2:0] {D_NONE, D_X, D_X2, D_SV, D_CV} dest_t;
  typedef enum logic [3:0] {DV2, DV6, DV12, DV20, DV30, DV42, DV56, DV72, DV90} div_t;

  typedef struct packed {
    logic   mac;
    a_sel_t a;
    b_sel_t b;
    base_t  base;
    shift_t sh;
    div_t   mdiv;
    wb_t    wb;
    dest_t  dest;
    div_t   wdiv;
  } uop_t;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_LAST = 5'd19;

  // reciprocal ceil(2^k / d), exact quotient for dividends below 2^31
  function automatic logic [OP_W-1:0] recip(input div_t d);
    case (d)
      DV6:     recip = OP_W'(((64'd1 << 34) + 64'd5) / 64'd6);
      DV12:    recip = OP_W'(((64'd1 << 35) + 64'd11) / 64'd12);
      DV20:    recip = OP_W'(((64'd1 << 36) + 64'd19) / 64'd20);
      DV30:    recip = OP_W'(((64'd1 << 36) + 64'd29) / 64'd30);
      DV42:    recip = OP_W'(((64'd1 << 37) + 64'd41) / 64'd42);
      DV56:    recip = OP_W'(((64'd1 << 37) + 64'd55) / 64'd56);
      DV72:    recip = OP_W'(((64'd1 << 38) + 64'd71) / 64'd72);
      DV90:    recip = OP_W'(((64'd1 << 38) + 64'd89) / 64'd90);
      default: recip = '0;
    endcase
  endfunction

  // quotient shift for each divisor; halving folds the mq rounding in
  function automatic logic [5:0] div_shift(input div_t d);
    case (d)
      DV2:     div_shift = 6'd31;
      DV6:     div_shift = 6'd34;
      DV12:    div_shift = 6'd35;
      DV20:    div_shift = 6'd36;
      DV30:    div_shift = 6'd36;
      DV42:    div_shift = 6'd37;
      DV56:    div_shift = 6'd37;
      DV72:    div_shift = 6'd38;
      DV90:    div_shift = 6'd38;
      default: div_shift = 6'd31;
    endcase
  endfunction

  function automatic uop_t mk(input logic mac, input a_sel_t a, input b_sel_t b,
                              input base_t base, input shift_t sh, input div_t mdiv,
                              input wb_t wb, input dest_t dest, input div_t wdiv);
    uop_t u;
    u.mac  = mac;
    u.a    = a;
    u.b    = b;
    u.base = base;
    u.sh   = sh;
    u.mdiv = mdiv;
    u.wb   = wb;
    u.dest = dest;
    u.wdiv = wdiv;
    return u;
  endfunction

  // angle to radians, then sine and cosine Horner chains
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = mk(1'b1, A_G,  B_DH,  BASE_R31,  SH20, DV2,  WB_NONE, D_NONE, DV2);
      5'd1:  u = mk(1'b1, A_G,  B_DL,  BASE_ACC,  SH0,  DV2,  WB_NONE, D_NONE, DV2);
      5'd2:  u = mk(1'b1, A_WB, B_WB,  BASE_R29,  SH0,  DV2,  WB_X,    D_X,    DV2);
      5'd3:  u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV72, WB_MQ,   D_X2,   DV2);
      5'd4:  u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV72);
      5'd5:  u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV42, WB_MQ,   D_NONE, DV2);
      5'd6:  u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV42);
      5'd7:  u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV20, WB_MQ,   D_NONE, DV2);
      5'd8:  u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV20);
      5'd9:  u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV6,  WB_MQ,   D_NONE, DV2);
      5'd10: u = mk(1'b1, A_X,  B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV6);
      5'd11: u = mk(1'b1, A_X2, B_RCP, BASE_ZERO, SH0,  DV90, WB_MQ,   D_SV,   DV2);
      5'd12: u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV90);
      5'd13: u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV56, WB_MQ,   D_NONE, DV2);
      5'd14: u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV56);
      5'd15: u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV30, WB_MQ,   D_NONE, DV2);
      5'd16: u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV30);
      5'd17: u = mk(1'b1, A_WB, B_RCP, BASE_ZERO, SH0,  DV12, WB_MQ,   D_NONE, DV2);
      5'd18: u = mk(1'b1, A_X2, B_WB,  BASE_R29,  SH0,  DV2,  WB_DIV,  D_NONE, DV12);
      5'd19: u = mk(1'b0, A_G,  B_DH,  BASE_ACC,  SH0,  DV2,  WB_DIV,  D_CV,   DV2);
      default: u = mk(1'b0, A_G, B_DH, BASE_ACC, SH0, DV2, WB_NONE, D_NONE, DV2);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/euler_channel_transform.sv =====
// -----------------------------------------------------------------------------
// euler_channel_transform
// Local joint transform from up to six translate / rotate channels
// -----------------------------------------------------------------------------
// A rotation runs channel select, angle reduction on the shared multiplier,
// quadrant split, 20 microcode steps and column mixing over the three rows;
// a translation runs channel select and a step for each of the three rows.
// The input is held off while an item runs and while a finished result waits
// for m_tready.
// Reset (rst, synchronous): control and configuration return to defaults.
`default_nettype none
`include "assert_macros.svh"

module euler_channel_transform
  import ect_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // value_0 .. value_5, VALUE_WIDTH bits each, from the lowest bit up
  input  wire logic [((NUM_VALUES*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // rot_00 .. rot_22 (32 bits each), move_x, move_y, move_z, lowest bit up
  output logic [((9*ROT_W+3*VALUE_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int ACC_W    = (VALUE_WIDTH + 36 > 68) ? VALUE_WIDTH + 36 : 68;
  localparam int IDX_W    = $clog2(MAX_CHANNELS);
  localparam int SUM_W    = VALUE_WIDTH + 2;
  // a full turn is 45 << 19, so the low 19 bits pass through the reduction
  localparam int LO_W     = 19;
  localparam int MOD_SH   = 35;
  localparam logic signed [OP_W-1:0] RCP45 = OP_W'(((64'd1 << MOD_SH) + 64'd44) / 64'd45);
  localparam longint WRAP_L = (longint'(1) << VALUE_WIDTH) % longint'(FULL_TURN);
  localparam logic [ANG_W-1:0] WRAP_MOD = WRAP_L[ANG_W-1:0];
  localparam logic signed [ACC_W-1:0] RND29 = ACC_W'(64'd1 << 29);
  localparam logic signed [ACC_W-1:0] RND31 = ACC_W'(64'd1 << 31);
  localparam logic signed [ACC_W-1:0] ONE_A = ACC_W'(Q30_ONE);
  localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] T_MIN = ~T_MAX;

  state_t state, state_next;

  logic [COUNT_W-1:0] cnt_reg;
  logic [KINDS_W-1:0] kinds_reg;

  logic signed [VALUE_WIDTH-1:0] vals [MAX_CHANNELS];
  logic [COUNT_W-1:0] n_ch, ch;
  kind_t kind_cur;
  kind_t kind_sel;
  logic signed [VALUE_WIDTH-1:0] vcur;
  logic [ANG_W-1:0] rmod;
  logic bitc;
  logic [1:0] quad;
  logic swap;
  logic [G_W-1:0] g;
  logic [PC_W-1:0] pc;
  logic [ROT_W-1:0] x, x2;
  logic signed [ROT_W-1:0] sv, cv, hold;
  logic signed [ACC_W-1:0] acc, acc_next;
  logic [1:0] row;
  logic [2:0] sub;
  logic signed [ROT_W-1:0] mat [3][3];
  logic signed [ROT_W-1:0] row_new [3];
  logic signed [VALUE_WIDTH-1:0] tv [3];
  logic signed [ROT_W-1:0] out_rot [9];
  logic signed [VALUE_WIDTH-1:0] out_mov [3];

  uop_t u;
  logic signed [OP_W-1:0] opa, opb, wbval;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext, prod_sh, base_val, acc_q;
  logic [ACC_W-1:0] acc_sh;
  shift_t sh_sel;
  base_t base_sel;
  logic mac_en;
  logic signed [ROT_W-1:0] s_fin, c_fin, sp, cp, mix_val, ent_a, ent_b;
  logic signed [SUM_W-1:0] tsum, tadd;
  logic signed [VALUE_WIDTH-1:0] tsat;
  logic [LO_W+31:0] uang;
  logic [31:0] ang_hi, ang_q, ang_r;
  logic [ANG_W:0] rfix_w;
  logic [ANG_W-1:0] rfix, gq, gsub;
  logic [1:0] quad_w;
  logic do_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_reg   <= COUNT_RESET;
      kinds_reg <= KINDS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_COUNT: cnt_reg <= cfg_data[COUNT_W-1:0];
        REG_KINDS: kinds_reg <= cfg_data[KINDS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign kind_sel = kinds_reg[ch*KIND_W +: KIND_W];
  assign u = ucode(pc);
  assign do_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // sine and cosine after octant swap and quadrant mapping
  always_comb begin
    sp = swap ? cv : sv;
    cp = swap ? sv : cv;
    case (quad)
      2'd0:    begin s_fin = sp;  c_fin = cp;  end
      2'd1:    begin s_fin = cp;  c_fin = -sp; end
      2'd2:    begin s_fin = -sp; c_fin = -cp; end
      default: begin s_fin = -cp; c_fin = sp;  end
    endcase
  end

  // row-0 entries for the current channel
  always_comb begin
    case (kind_cur)
      KIND_MOVE_X: begin ent_a = mat[0][0]; ent_b = mat[0][1]; end
      KIND_MOVE_Y: begin ent_a = mat[0][1]; ent_b = mat[0][2]; end
      KIND_MOVE_Z: begin ent_a = mat[0][2]; ent_b = mat[0][0]; end
      KIND_ROT_X:  begin ent_a = mat[0][1]; ent_b = mat[0][2]; end
      KIND_ROT_Y:  begin ent_a = mat[0][2]; ent_b = mat[0][0]; end
      default:     begin ent_a = mat[0][0]; ent_b = mat[0][1]; end
    endcase
  end

  // rotated row 0 with its two mixed columns
  always_comb begin
    row_new = mat[0];
    case (kind_cur)
      KIND_ROT_X: begin row_new[1] = hold; row_new[2] = mix_val; end
      KIND_ROT_Y: begin row_new[2] = hold; row_new[0] = mix_val; end
      default:    begin row_new[0] = hold; row_new[1] = mix_val; end
    endcase
  end

  // writeback value taken from the accumulator of the previous step
  always_comb begin
    acc_sh = ACC_W'(acc) >> div_shift(u.wdiv);
    case (u.wb)
      WB_X:    wbval = {1'b0, acc[63:32]};
      WB_MQ:   wbval = {1'b0, acc[61:30]};
      WB_DIV:  wbval = OP_W'(Q30_ONE) - {1'b0, acc_sh[31:0]};
      default: wbval = '0;
    endcase
  end

  // operand selection for the shared multiply-accumulate unit
  always_comb begin
    opa      = '0;
    opb      = '0;
    base_sel = BASE_ACC;
    sh_sel   = SH0;
    mac_en   = 1'b0;
    case (state)
      S_MOD: begin
        // quotient of the angle's upper bits by 45 through a reciprocal
        mac_en   = bitc;
        opa      = OP_W'(ang_hi);
        opb      = RCP45;
        base_sel = BASE_ZERO;
      end
      S_TRIG: begin
        mac_en   = u.mac;
        base_sel = u.base;
        sh_sel   = u.sh;
        case (u.a)
          A_G:     opa = OP_W'(g);
          A_X:     opa = {1'b0, x};
          A_X2:    opa = {1'b0, x2};
          default: opa = wbval;
        endcase
        case (u.b)
          B_DH:    opb = DEG_HI;
          B_DL:    opb = DEG_LO;
          B_WB:    opb = wbval;
          default: opb = recip(u.mdiv);
        endcase
      end
      S_ROT: begin
        mac_en = (sub < 3'd4);
        case (sub)
          3'd0:    begin opa = OP_W'(ent_a); opb = OP_W'(c_fin);  base_sel = BASE_R29; end
          3'd1:    begin opa = OP_W'(ent_b); opb = OP_W'(s_fin);  base_sel = BASE_ACC; end
          3'd2:    begin opa = OP_W'(ent_a); opb = -OP_W'(s_fin); base_sel = BASE_R29; end
          default: begin opa = OP_W'(ent_b); opb = OP_W'(c_fin);  base_sel = BASE_ACC; end
        endcase
      end
      S_MOVE: begin
        mac_en = (sub < 3'd2);
        opa    = OP_W'(ent_a);
        if (sub == 3'd0) begin
          opb      = OP_W'(vcur >>> 16);
          base_sel = BASE_R29;
          sh_sel   = SH16;
        end else begin
          opb      = OP_W'(vcur[15:0]);
          base_sel = BASE_ACC;
        end
      end
      default: ;
    endcase
  end

  // shared multiplier and accumulator adder
  always_comb begin
    prod     = opa * opb;
    prod_ext = ACC_W'(prod);
    case (sh_sel)
      SH16:    prod_sh = prod_ext <<< 16;
      SH20:    prod_sh = prod_ext <<< 20;
      default: prod_sh = prod_ext;
    endcase
    case (base_sel)
      BASE_ZERO: base_val = '0;
      BASE_R29:  base_val = RND29;
      BASE_R31:  base_val = RND31;
      default:   base_val = acc;
    endcase
    acc_next = base_val + prod_sh;
  end

  // q30 rounding result, clamped matrix entry and saturated translation
  always_comb begin
    acc_q = acc >>> 30;
    if (acc_q > ONE_A) begin
      mix_val = Q30_ONE;
    end else if (acc_q < -ONE_A) begin
      mix_val = -Q30_ONE;
    end else begin
      mix_val = acc_q[ROT_W-1:0];
    end
    tadd = acc_q[SUM_W-1:0];
    tsum = SUM_W'(tv[0]) + tadd;
    if (tsum > T_MAX) begin
      tsat = T_MAX[VALUE_WIDTH-1:0];
    end else if (tsum < T_MIN) begin
      tsat = T_MIN[VALUE_WIDTH-1:0];
    end else begin
      tsat = tsum[VALUE_WIDTH-1:0];
    end
  end

  // angle reduction: remainder of the raw bits by a full turn, sign fix,
  // then quadrant split
  always_comb begin
    uang   = {{(LO_W+32-VALUE_WIDTH){1'b0}}, vcur};
    ang_hi = uang[LO_W +: 32];
    ang_q  = acc[MOD_SH +: 32];
    ang_r  = ang_hi - ang_q * 32'd45;
    if (vcur[VALUE_WIDTH-1]) begin
      rfix_w = (rmod >= WRAP_MOD) ? {1'b0, rmod - WRAP_MOD}
                                  : {1'b0, rmod} + {1'b0, FULL_TURN} - {1'b0, WRAP_MOD};
    end else begin
      rfix_w = {1'b0, rmod};
    end
    rfix = rfix_w[ANG_W-1:0];
    if (rfix >= THREE_QUART) begin
      quad_w = 2'd3;
      gq     = rfix - THREE_QUART;
    end else if (rfix >= HALF_TURN) begin
      quad_w = 2'd2;
      gq     = rfix - HALF_TURN;
    end else if (rfix >= QUARTER_TURN) begin
      quad_w = 2'd1;
      gq     = rfix - QUARTER_TURN;
    end else begin
      quad_w = 2'd0;
      gq     = rfix;
    end
    gsub = QUARTER_TURN - gq;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_CHAN;
      S_CHAN: begin
        if (ch == n_ch) begin
          state_next = S_DONE;
        end else if (kind_sel <= KIND_MOVE_Z) begin
          state_next = S_MOVE;
        end else if (kind_sel <= KIND_ROT_Z) begin
          state_next = S_MOD;
        end
      end
      S_MOD:  if (!bitc) state_next = S_QUAD;
      S_QUAD: state_next = S_TRIG;
      S_TRIG: if (pc == PC_LAST) state_next = S_ROT;
      S_ROT:  if (row == 2'd2 && sub == 3'd4) state_next = S_CHAN;
      S_MOVE: if (row == 2'd2 && sub == 3'd2) state_next = S_CHAN;
      S_DONE: if (do_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mac_en) begin
      acc <= acc_next;
    end
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            vals[i] <= s_tdata[i*VALUE_WIDTH +: VALUE_WIDTH];
          end
          n_ch <= (cnt_reg > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS) : cnt_reg;
          ch   <= '0;
          for (int i = 0; i < 3; i++) begin
            tv[i] <= '0;
            for (int j = 0; j < 3; j++) begin
              mat[i][j] <= (i == j) ? Q30_ONE : '0;
            end
          end
        end
      end
      S_CHAN: begin
        if (ch != n_ch) begin
          kind_cur <= kind_sel;
          vcur     <= vals[ch[IDX_W-1:0]];
          rmod     <= '0;
          bitc     <= 1'b1;
          row      <= '0;
          sub      <= '0;
          pc       <= '0;
          if (kind_sel > KIND_ROT_Z) begin
            ch <= ch + 1'b1;
          end
        end
      end
      S_MOD: begin
        // after the quotient pass: remainder from the quotient, low bits pass through
        if (!bitc) begin
          rmod <= {ang_r[5:0], uang[LO_W-1:0]};
        end
        bitc <= 1'b0;
      end
      S_QUAD: begin
        quad <= quad_w;
        swap <= (gq > EIGHTH_TURN);
        g    <= (gq > EIGHTH_TURN) ? gsub[G_W-1:0] : gq[G_W-1:0];
      end
      S_TRIG: begin
        pc <= pc + 1'b1;
        case (u.dest)
          D_X:     x  <= wbval[ROT_W-1:0];
          D_X2:    x2 <= wbval[ROT_W-1:0];
          D_SV:    sv <= wbval[ROT_W-1:0];
          D_CV:    cv <= wbval[ROT_W-1:0];
          default: ;
        endcase
      end
      S_ROT: begin
        if (sub == 3'd2) begin
          hold <= mix_val;
        end
        if (sub == 3'd4) begin
          // retire row 0 to the bottom so the next row moves up
          mat[0] <= mat[1];
          mat[1] <= mat[2];
          mat[2] <= row_new;
          sub <= '0;
          row <= row + 1'b1;
          if (row == 2'd2) begin
            ch <= ch + 1'b1;
          end
        end else begin
          sub <= sub + 1'b1;
        end
      end
      S_MOVE: begin
        if (sub == 3'd2) begin
          mat[0] <= mat[1];
          mat[1] <= mat[2];
          mat[2] <= mat[0];
          tv[0]  <= tv[1];
          tv[1]  <= tv[2];
          tv[2]  <= tsat;
          sub    <= '0;
          row    <= row + 1'b1;
          if (row == 2'd2) begin
            ch <= ch + 1'b1;
          end
        end else begin
          sub <= sub + 1'b1;
        end
      end
      S_DONE: begin
        if (do_load) begin
          for (int i = 0; i < 3; i++) begin
            out_mov[i] <= tv[i];
            for (int j = 0; j < 3; j++) begin
              out_rot[i*3+j] <= mat[i][j];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result packing
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      m_tdata[i*ROT_W +: ROT_W] = out_rot[i];
    end
    for (int i = 0; i < 3; i++) begin
      m_tdata[9*ROT_W + i*VALUE_WIDTH +: VALUE_WIDTH] = out_mov[i];
    end
  end

  // checks
  `ASSERT_IMPLIES(a_ch_bound, clk, rst, state == S_CHAN, ch <= n_ch)
  `ASSERT_IMPLIES(a_mod_range, clk, rst, state == S_QUAD, rmod < FULL_TURN)
  `ASSERT_IMPLIES(a_octant, clk, rst, state == S_TRIG, {3'b000, g} <= EIGHTH_TURN)
  `ASSERT_IMPLIES(a_trig_unit, clk, rst, state == S_ROT, sv <= Q30_ONE && cv <= Q30_ONE)
  `ASSERT_NEXT(a_accept_start, clk, rst, s_tvalid && s_tready, state == S_CHAN)

endmodule

`default_nettype wire

// ===== tb/euler_channel_transform_checker.sv =====
// -----------------------------------------------------------------------------
// euler_channel_transform_checker
// Watches the item channels and the register port of the channel transform,
// works out each joint transform in fixed point and compares every field of
// the result stream in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_channel_transform_checker
  import ect_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [191:0]  s_tdata,
  input  logic          m_tvalid,
  input  logic          m_tready,
  input  logic [383:0]  m_tdata,
  output int            fail_count,
  output int            pending,
  output int            result_count
);

  localparam longint Q1     = 64'sd1073741824;
  localparam longint TURN   = 360 * 65536;
  localparam longint QUART  = 90 * 65536;
  localparam longint EIGHTH = 45 * 65536;
  localparam longint VMAX   = 64'sd2147483647;
  localparam longint VMIN   = -64'sd2147483648;
  localparam longint unsigned RAD_SCALE = 64'd1228166276394;

  logic [COUNT_W-1:0] joint_count;
  logic [KINDS_W-1:0] joint_kinds;
  logic [383:0] transform_queue[$];

  // arithmetic shift right with floor
  function automatic longint floor_shift(input longint x, input int n);
    return x >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned mulq(input longint unsigned a,
                                           input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // fixed-point sine and cosine of an angle in Q16.16 degrees
  function automatic void angle_trig(input longint ang, output longint sn,
                                     output longint cs);
    longint r, sv, cv, tmp;
    longint unsigned quad, g, x, x2, t, one;
    logic swap;
    r = ang % TURN;
    if (r < 0) r += TURN;
    quad = r / QUART;
    g = r % QUART;
    swap = g > EIGHTH;
    if (swap) g = QUART - g;
    x = (g * RAD_SCALE + (64'd1 << 31)) >> 32;
    x2 = mulq(x, x);
    one = Q1;
    t = one - x2 / 72;
    t = one - mulq(x2, t) / 42;
    t = one - mulq(x2, t) / 20;
    t = one - mulq(x2, t) / 6;
    sv = mulq(x, t);
    t = one - x2 / 90;
    t = one - mulq(x2, t) / 56;
    t = one - mulq(x2, t) / 30;
    t = one - mulq(x2, t) / 12;
    cv = one - mulq(x2, t) / 2;
    if (swap) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    case (quad)
      0: begin sn = sv;  cs = cv;  end
      1: begin sn = cv;  cs = -sv; end
      2: begin sn = -sv; cs = -cv; end
      default: begin sn = -cv; cs = sv; end
    endcase
  endfunction

  function automatic longint blend(input longint p, input longint u,
                                   input longint q, input longint w);
    return clip(floor_shift(p * u + q * w + (64'sd1 << 29), 30), -Q1, Q1);
  endfunction

  // round-half-up of r * a / 2^30, split to stay inside 64 bits
  function automatic longint scale_move(input longint r, input longint a);
    longint ah, al, hi, lo, low14;
    ah = floor_shift(a, 16);
    al = a - ah * 65536;
    hi = r * ah;
    lo = r * al;
    low14 = hi & 64'h3fff;
    return floor_shift(hi, 14) + floor_shift(low14 * 65536 + lo + (64'sd1 << 29), 30);
  endfunction

  // whole joint transform for one item, packed like the result bus
  function automatic logic [383:0] joint_transform(input logic [191:0] vals);
    longint m[3][3];
    longint t[3];
    longint v, s, c, a, b;
    int n, j, k;
    kind_t kd;
    logic [383:0] res;
    for (int i = 0; i < 3; i++) begin
      t[i] = 0;
      for (int jj = 0; jj < 3; jj++) m[i][jj] = (i == jj) ? Q1 : 0;
    end
    n = joint_count > 6 ? 6 : joint_count;
    for (int ch = 0; ch < n; ch++) begin
      v = longint'($signed(vals[ch*32 +: 32]));
      kd = joint_kinds[3*ch +: 3];
      if (kd <= KIND_MOVE_Z) begin
        for (int i = 0; i < 3; i++)
          t[i] = clip(t[i] + scale_move(m[i][kd], v), VMIN, VMAX);
      end else if (kd <= KIND_ROT_Z) begin
        angle_trig(v, s, c);
        case (kd)
          KIND_ROT_X: begin j = 1; k = 2; end
          KIND_ROT_Y: begin j = 2; k = 0; end
          default:    begin j = 0; k = 1; end
        endcase
        for (int i = 0; i < 3; i++) begin
          a = m[i][j];
          b = m[i][k];
          m[i][j] = blend(a, c, b, s);
          m[i][k] = blend(a, -s, b, c);
        end
      end
    end
    for (int i = 0; i < 9; i++) res[i*32 +: 32] = m[i/3][i%3][31:0];
    for (int i = 0; i < 3; i++) res[(9+i)*32 +: 32] = t[i][31:0];
    return res;
  endfunction

  assign pending = transform_queue.size();

  // register shadow, prediction on input items, comparison on result items
  always @(posedge clk) begin
    logic [383:0] want;
    int errs;
    errs = 0;
    if (rst) begin
      joint_count <= COUNT_RESET;
      joint_kinds <= KINDS_RESET;
      transform_queue.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_COUNT) joint_count <= cfg_data[COUNT_W-1:0];
        else joint_kinds <= cfg_data[KINDS_W-1:0];
      end
      if (s_tvalid && s_tready) transform_queue.push_back(joint_transform(s_tdata));
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (transform_queue.size() == 0) begin
          $error("result item with no transform expected");
          errs = 1;
        end else begin
          want = transform_queue.pop_front();
          for (int f = 0; f < 12; f++) begin
            if (want[f*32 +: 32] !== m_tdata[f*32 +: 32]) begin
              $error("%s expected %0d actual %0d",
                     f < 9 ? $sformatf("rot_%0d%0d", f/3, f%3)
                           : $sformatf("move_%s", f == 9 ? "x" : (f == 10 ? "y" : "z")),
                     $signed(want[f*32 +: 32]), $signed(m_tdata[f*32 +: 32]));
              errs = errs + 1;
            end
          end
        end
        if (errs != 0) fail_count <= fail_count + errs;
      end
    end
  end

endmodule

// ===== tb/euler_channel_transform_tb.sv =====
// -----------------------------------------------------------------------------
// euler_channel_transform_tb
// Drives joint channel items and register settings into the channel
// transform with random stalls on both sides; the checker judges the results.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_channel_transform_tb;
  import ect_pkg::*;

  localparam int RAND_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [191:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [383:0] m_tdata;
  int fail_count, pending, result_count;
  int cycle_count = 0;
  int item_count = 0;
  int setting_count = 0;
  logic calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  euler_channel_transform DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  euler_channel_transform_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // receiver stalls, none during calm stretches
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 33);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("euler_channel_transform: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop the input and drain outstanding results before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid stays up after an accept until the next item or an idle cycle
  task automatic send_joint(input logic [191:0] vals);
    while (!calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= vals;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    item_count++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'(($urandom_range(720) - 360) * 65536);
      2: return 32'(($urandom_range(8) * 45 - 180) * 65536 + $urandom_range(2) - 1);
      3: return {{16{1'b0}}, 16'($urandom())} ^ {32{$urandom_range(1) == 1}};
      4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
    endcase
  endfunction

  function automatic logic [191:0] random_joint();
    logic [191:0] v;
    for (int i = 0; i < 6; i++) v[i*32 +: 32] = random_value();
    return v;
  endfunction

  function automatic logic [191:0] same_joint(input logic [31:0] x);
    return {6{x}};
  endfunction

  task automatic apply_setting(input logic [2:0] cnt, input logic [17:0] kinds);
    wait_idle();
    write_reg(REG_COUNT, CFG_W'(cnt));
    write_reg(REG_KINDS, kinds);
    setting_count++;
  endtask

  function automatic logic [17:0] random_kinds();
    logic [17:0] k;
    for (int i = 0; i < 6; i++)
      k[3*i +: 3] = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                              : 3'($urandom_range(5));
    return k;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    calm <= 1'b1;

    // directed: reset setting, extremes, wide angles, quadrant edges
    send_joint('0);
    send_joint(same_joint(32'h7fffffff));
    send_joint(same_joint(32'h80000000));
    send_joint(same_joint(32'(45 * 65536)));
    send_joint(same_joint(32'(90 * 65536)));
    send_joint(same_joint(32'(-270 * 65536)));
    send_joint(same_joint(32'(720 * 65536 + 1)));
    send_joint(same_joint(32'hffffffff));
    // each operation alone, count above the maximum, unused codes, zero count
    for (int kd = 0; kd < 8; kd++) begin
      apply_setting(3'd7, {6{3'(kd)}});
      send_joint(same_joint(32'(30 * 65536)));
      send_joint(same_joint(32'h7fffffff));
    end
    apply_setting(3'd0, 18'h3ffff);
    send_joint(random_joint());
    apply_setting(3'd2, 18'd0);
    send_joint(same_joint(32'h80000000));
    calm <= 1'b0;

    // random settings, each with a batch of random joints
    while (item_count < RAND_ITEMS + 25) begin
      apply_setting(3'($urandom_range(7)), random_kinds());
      calm <= ($urandom_range(9) == 0);
      repeat ($urandom_range(60, 20)) send_joint(random_joint());
      calm <= 1'b0;
    end
    apply_setting(3'd6, 18'd146056);
    repeat (20) send_joint(random_joint());

    wait_idle();
    repeat (300) @(posedge clk);
    $display("covered %0d joint items over %0d register settings, %0d results checked",
             item_count, setting_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("euler_channel_transform: match");
    end else begin
      $display("euler_channel_transform: mismatch");
    end
    $finish;
  end

endmodule

// ===== euler_channel_transform.f =====
+incdir+design
design/ect_pkg.sv
design/euler_channel_transform.sv
tb/euler_channel_transform_checker.sv
tb/euler_channel_transform_tb.sv
